[rtl/core/adll_pkg.sv]
// Shared types and codes of the slot-table doubly linked list engine.
// Depends on nothing; every file of the block but adll_ram imports it.
package adll_pkg;

	typedef enum logic [2:0] {
		OP_ADD_FRONT = 3'd0,
		OP_ADD_END   = 3'd1,
		OP_INSERT    = 3'd2,
		OP_REMOVE    = 3'd3,
		OP_READ      = 3'd4,
		OP_WRITE     = 3'd5,
		OP_SEARCH    = 3'd6,
		OP_HEAD      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Classification that the front attaches to each beat.
	typedef struct packed {
		op_t  op;
		logic slot_ref;
		logic alloc;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RD,
		B_EX,
		B_W2,
		B_SRD,
		B_SCMP,
		B_OUT
	} bstate_t;

endpackage

[rtl/core/adll_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module adll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/adll_front.sv]
// Front part: accepts request beats, classifies them and holds them in a
// two-entry queue towards the back part. Depends on adll_pkg.
module adll_front #(
	parameter int SLOTS      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [2:0]               operation,
	input  logic [$clog2(SLOTS)-1:0] slot,
	input  logic [ELEM_WIDTH-1:0]    value,
	output logic                     q_valid,
	input  logic                     q_ready,
	output adll_pkg::cmd_t           q_cmd,
	output logic [$clog2(SLOTS)-1:0] q_slot,
	output logic [ELEM_WIDTH-1:0]    q_value
);
	import adll_pkg::*;

	localparam int SW = $clog2(SLOTS);

	cmd_t                  cmd_q   [2];
	logic [SW-1:0]         slot_q  [2];
	logic [ELEM_WIDTH-1:0] value_q [2];
	logic                  wr_q, rd_q;
	logic [1:0]            fill_q;
	cmd_t                  in_cmd;
	logic                  push, pop;

	always_comb begin
		in_cmd.op = op_t'(operation);
		in_cmd.slot_ref = 1'b0;
		in_cmd.alloc = 1'b0;
		unique case (in_cmd.op)
			OP_ADD_FRONT, OP_ADD_END: in_cmd.alloc = 1'b1;
			OP_INSERT: begin
				in_cmd.alloc = 1'b1;
				in_cmd.slot_ref = 1'b1;
			end
			OP_REMOVE, OP_READ, OP_WRITE: in_cmd.slot_ref = 1'b1;
			default: in_cmd.slot_ref = 1'b0;
		endcase
	end

	assign req_ready = (fill_q != 2'd2);
	assign push = req_valid && req_ready;
	assign q_valid = (fill_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = cmd_q[rd_q];
	assign q_slot = slot_q[rd_q];
	assign q_value = value_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q] <= in_cmd;
			slot_q[wr_q] <= slot;
			value_q[wr_q] <= value;
		end
	end
endmodule

[rtl/core/adll_back.sv]
// Back part: carries out list operations on the slot table and free stack,
// and holds the result register. Depends on adll_pkg and adll_ram.
module adll_back #(
	parameter int SLOTS      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  adll_pkg::cmd_t             q_cmd,
	input  logic [$clog2(SLOTS)-1:0]   q_slot,
	input  logic [ELEM_WIDTH-1:0]      q_value,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [1:0]                 status,
	output logic [ELEM_WIDTH-1:0]      old_value,
	output logic [$clog2(SLOTS+1)-1:0] result_slot,
	output logic [$clog2(SLOTS+1)-1:0] list_head,
	output logic [$clog2(SLOTS+1)-1:0] element_count
);
	import adll_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam logic [PW-1:0] NONE = PW'(SLOTS);

	bstate_t st_q, st_d;
	cmd_t cmd_q;
	logic [SW-1:0] slot_q;
	logic [ELEM_WIDTH-1:0] val_q, old_q;
	logic [PW-1:0] cur_q, rslot_q, head_q, tail_q, cnt_q, ftop_q, fresh_q;
	logic [PW-1:0] wan_q, wap_q, nvn_q, nvp_q;
	logic wen_q, wep_q;
	status_t stat_q;
	logic [SLOTS-1:0] occ_q;

	logic e_we, n_we, p_we, f_we;
	logic [SW-1:0] e_wa, n_wa, p_wa, f_wa, e_ra, n_ra, f_ra;
	logic [ELEM_WIDTH-1:0] e_wd, e_rd;
	logic [PW-1:0] n_wd, p_wd, n_rd, p_rd;
	logic [SW-1:0] f_rd;
	logic [PW-1:0] alloc_s, slot_p, q_slot_p;
	logic first, tail_case, out_load;

	function automatic logic live(input logic [PW-1:0] p, input logic [SLOTS-1:0] occ);
		logic r;
		r = 1'b0;
		if (p < NONE) begin
			r = occ[p[SW-1:0]];
		end
		return r;
	endfunction

	assign slot_p = PW'(slot_q);
	assign q_slot_p = PW'(q_slot);
	assign alloc_s = (ftop_q != '0) ? PW'(f_rd) : fresh_q;
	assign first = (cnt_q == '0);
	assign tail_case = (cmd_q.op == OP_ADD_END) || (slot_p == tail_q);
	assign out_load = (st_q == B_OUT) && (!rsp_valid || rsp_ready);

	adll_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(SLOTS)) u_elem (.clk(clk), .we(e_we),
		.waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
	adll_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next (.clk(clk), .we(n_we),
		.waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
	adll_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev (.clk(clk), .we(p_we),
		.waddr(p_wa), .wdata(p_wd), .raddr(slot_q), .rdata(p_rd));
	adll_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_fstk (.clk(clk), .we(f_we),
		.waddr(f_wa), .wdata(slot_q), .raddr(f_ra), .rdata(f_rd));

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == OP_HEAD) begin
						st_d = B_OUT;
					end else if (q_cmd.op == OP_SEARCH) begin
						st_d = B_SRD;
					end else if (q_cmd.slot_ref && !live(q_slot_p, occ_q)) begin
						st_d = B_OUT;
					end else if (q_cmd.alloc && ftop_q == '0 && fresh_q == NONE) begin
						st_d = B_OUT;
					end else begin
						st_d = B_RD;
					end
				end
			end
			B_RD: st_d = B_EX;
			B_EX: st_d = (cmd_q.alloc && !first) ? B_W2 : B_OUT;
			B_W2: st_d = B_OUT;
			B_SRD: st_d = live(cur_q, occ_q) ? B_SCMP : B_OUT;
			B_SCMP: st_d = (e_rd == val_q) ? B_OUT : B_SRD;
			B_OUT: st_d = out_load ? B_IDLE : B_OUT;
			default: st_d = B_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		q_ready = (st_q == B_IDLE);
		e_ra = (st_q == B_SRD) ? cur_q[SW-1:0] : slot_q;
		n_ra = e_ra;
		f_ra = SW'(ftop_q - PW'(1));
		e_we = 1'b0;
		e_wa = slot_q;
		e_wd = val_q;
		n_we = 1'b0;
		n_wa = wan_q[SW-1:0];
		n_wd = nvn_q;
		p_we = 1'b0;
		p_wa = wap_q[SW-1:0];
		p_wd = nvp_q;
		f_we = 1'b0;
		f_wa = ftop_q[SW-1:0];
		unique case (st_q)
			B_EX: begin
				unique case (cmd_q.op)
					OP_ADD_FRONT, OP_ADD_END, OP_INSERT: begin
						e_we = 1'b1;
						e_wa = alloc_s[SW-1:0];
						n_we = 1'b1;
						n_wa = alloc_s[SW-1:0];
						p_we = 1'b1;
						p_wa = alloc_s[SW-1:0];
						if (first) begin
							n_wd = NONE;
							p_wd = NONE;
						end else if (cmd_q.op == OP_ADD_FRONT) begin
							n_wd = head_q;
							p_wd = NONE;
						end else if (tail_case) begin
							n_wd = NONE;
							p_wd = (cmd_q.op == OP_ADD_END) ? tail_q : slot_p;
						end else begin
							n_wd = n_rd;
							p_wd = slot_p;
						end
					end
					OP_REMOVE: begin
						n_we = live(p_rd, occ_q);
						n_wa = p_rd[SW-1:0];
						n_wd = n_rd;
						p_we = live(n_rd, occ_q);
						p_wa = n_rd[SW-1:0];
						p_wd = p_rd;
						f_we = 1'b1;
					end
					OP_WRITE: e_we = 1'b1;
					default: e_we = 1'b0;
				endcase
			end
			B_W2: begin
				n_we = wen_q;
				p_we = wep_q;
			end
			default: q_ready = (st_q == B_IDLE);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			occ_q <= '0;
			head_q <= NONE;
			tail_q <= NONE;
			cnt_q <= '0;
			ftop_q <= '0;
			fresh_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (st_q == B_EX) begin
				unique case (cmd_q.op)
					OP_ADD_FRONT, OP_ADD_END, OP_INSERT: begin
						if (ftop_q != '0) begin
							ftop_q <= ftop_q - PW'(1);
						end else begin
							fresh_q <= fresh_q + PW'(1);
						end
						occ_q[alloc_s[SW-1:0]] <= 1'b1;
						cnt_q <= cnt_q + PW'(1);
						if (first) begin
							head_q <= alloc_s;
							tail_q <= alloc_s;
						end else if (cmd_q.op == OP_ADD_FRONT) begin
							head_q <= alloc_s;
						end else if (tail_case) begin
							tail_q <= alloc_s;
						end
					end
					OP_REMOVE: begin
						ftop_q <= ftop_q + PW'(1);
						occ_q[slot_q] <= 1'b0;
						cnt_q <= cnt_q - PW'(1);
						if (cnt_q == PW'(1)) begin
							head_q <= NONE;
							tail_q <= NONE;
						end else begin
							if (slot_p == head_q) begin
								head_q <= n_rd;
							end
							if (slot_p == tail_q) begin
								tail_q <= p_rd;
							end
						end
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && q_valid) begin
			cmd_q <= q_cmd;
			slot_q <= q_slot;
			val_q <= q_value;
			cur_q <= head_q;
			old_q <= '0;
			rslot_q <= (q_cmd.op == OP_HEAD) ? head_q : NONE;
			if (q_cmd.slot_ref && !live(q_slot_p, occ_q)) begin
				stat_q <= ST_INVALID;
			end else if (q_cmd.alloc && ftop_q == '0 && fresh_q == NONE) begin
				stat_q <= ST_FULL;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (st_q == B_EX) begin
			if (cmd_q.alloc) begin
				rslot_q <= alloc_s;
				wen_q <= (cmd_q.op != OP_ADD_FRONT);
				wep_q <= (cmd_q.op == OP_ADD_FRONT) || !tail_case;
				wan_q <= (cmd_q.op == OP_ADD_END) ? tail_q : slot_p;
				wap_q <= (cmd_q.op == OP_ADD_FRONT) ? head_q : n_rd;
				nvn_q <= alloc_s;
				nvp_q <= alloc_s;
			end else begin
				old_q <= e_rd;
			end
		end
		if (st_q == B_SCMP) begin
			if (e_rd == val_q) begin
				rslot_q <= cur_q;
			end else begin
				cur_q <= n_rd;
			end
		end
		if (out_load) begin
			status <= stat_q;
			old_value <= old_q;
			result_slot <= rslot_q;
			list_head <= head_q;
			element_count <= cnt_q;
		end
	end
endmodule

[rtl/core/array_doubly_linked_list_engine.sv]
// Top level of the slot-table doubly linked list engine with free stack.
// Depends on adll_pkg, adll_front, adll_back and adll_ram.
//
//   Channel   Handshake              Beat fields
//   request   req_valid / req_ready  operation, slot, value
//   response  rsp_valid / rsp_ready  status, old_value, result_slot,
//                                    list_head, element_count
//
// Head read and error beats go straight to the back part's output state;
// read, write, remove and adds pass a read and an execute state, adds to a
// non-empty list also a link-write state (neighbour links share the RAM
// write port). A search walks from the head to a match or the list end.
// Reset is asynchronous; the tables need no clearing pass.
// The two-entry queue takes requests until it is full while a response is stalled.
module array_doubly_linked_list_engine #(
	parameter int SLOTS      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [2:0]                 operation,
	input  logic [$clog2(SLOTS)-1:0]   slot,
	input  logic [ELEM_WIDTH-1:0]      value,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [1:0]                 status,
	output logic [ELEM_WIDTH-1:0]      old_value,
	output logic [$clog2(SLOTS+1)-1:0] result_slot,
	output logic [$clog2(SLOTS+1)-1:0] list_head,
	output logic [$clog2(SLOTS+1)-1:0] element_count
);
	import adll_pkg::*;

	logic                     q_valid, q_ready;
	cmd_t                     q_cmd;
	logic [$clog2(SLOTS)-1:0] q_slot;
	logic [ELEM_WIDTH-1:0]    q_value;

	adll_front #(.SLOTS(SLOTS), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .slot(slot), .value(value),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .q_slot(q_slot), .q_value(q_value)
	);

	adll_back #(.SLOTS(SLOTS), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .q_slot(q_slot), .q_value(q_value),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .old_value(old_value), .result_slot(result_slot),
		.list_head(list_head), .element_count(element_count)
	);
endmodule

[rtl/core/adll_checker.sv]
// Port-level checker for the list engine, bound to the top level.
// Depends on adll_pkg and array_doubly_linked_list_engine.
module adll_checker #(
	parameter int SLOTS      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [1:0]                 status,
	input logic [ELEM_WIDTH-1:0]      old_value,
	input logic [$clog2(SLOTS+1)-1:0] result_slot,
	input logic [$clog2(SLOTS+1)-1:0] list_head,
	input logic [$clog2(SLOTS+1)-1:0] element_count
);
	import adll_pkg::*;

	localparam int PW = $clog2(SLOTS + 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_slot) && $stable(status))
		else $error("response beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((element_count == '0) == (list_head == PW'(SLOTS))))
		else $error("head and element count disagree");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> element_count <= PW'(SLOTS))
		else $error("element count beyond table size");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> element_count == PW'(SLOTS)
			&& result_slot == PW'(SLOTS) && old_value == '0)
		else $error("full status with free slots");
endmodule

bind array_doubly_linked_list_engine adll_checker #(.SLOTS(SLOTS), .ELEM_WIDTH(ELEM_WIDTH))
	u_adll_checker (.*);
